// ===== rtl/core/kwlex_pkg.sv =====
package kwlex_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_DOT   = 3'd3,
    MODE_FRAC  = 3'd4,
    MODE_OP    = 3'd5,
    MODE_STR   = 3'd6
  } mode_t;

  localparam logic [5:0] K_IDENT   = 6'd10;
  localparam logic [5:0] K_UNKNOWN = 6'd11;
  localparam logic [5:0] K_STRING  = 6'd12;
  localparam logic [5:0] K_NUMBER  = 6'd13;
  localparam logic [5:0] K_DOT     = 6'd19;
  localparam logic [5:0] K_END     = 6'd34;
  localparam logic [5:0] K_BAD     = 6'd35;
  localparam logic [5:0] K_NONE    = 6'd63;

  localparam logic [47:0] WIN_FULL = 48'hFFFF_FFFF_FFFF;

  // one token word as the front produces it; offsets already cut to 32 bits
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic        last;
  } tok_t;

  localparam int TOK_W = $bits(tok_t);

  // up to four tokens caused by one input word
  typedef struct packed {
    logic [2:0]  cnt;
    tok_t [3:0]  tok;
  } grp_t;

  localparam int GRP_W = $bits(grp_t);

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      8'h28:   k = 6'd14;
      8'h29:   k = 6'd15;
      8'h7B:   k = 6'd16;
      8'h7D:   k = 6'd17;
      8'h2C:   k = 6'd18;
      8'h2E:   k = 6'd19;
      8'h2D:   k = 6'd20;
      8'h2B:   k = 6'd21;
      8'h2A:   k = 6'd22;
      8'h2F:   k = 6'd23;
      8'h3A:   k = 6'd24;
      8'h3B:   k = 6'd33;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] op, input logic two);
    logic [5:0] k;
    unique case (op)
      8'h21:   k = two ? 6'd25 : 6'd26;
      8'h3E:   k = two ? 6'd27 : 6'd28;
      8'h3C:   k = two ? 6'd29 : 6'd30;
      default: k = two ? 6'd31 : 6'd32;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] kw_kind(input logic [47:0] w);
    logic [5:0] k;
    unique case (w)
      48'h0000_006C_6574: k = 6'd0;  // let
      48'h0000_564F_4944: k = 6'd1;  // VOID
      48'h0000_4259_5445: k = 6'd2;  // BYTE
      48'h0000_574F_5244: k = 6'd3;  // WORD
      48'h0044_574F_5244: k = 6'd4;  // DWORD
      48'h0051_574F_5244: k = 6'd5;  // QWORD
      48'h7265_7475_726E: k = 6'd6;  // return
      48'h0000_0000_6966: k = 6'd7;  // if
      48'h0000_656C_7365: k = 6'd8;  // else
      48'h0000_6675_6E63: k = 6'd9;  // func
      default:            k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/kwlex_front.sv =====
module kwlex_front import kwlex_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] char_byte,
  input  logic       byte_present,
  input  logic       end_of_input,
  input  logic       take,
  output grp_t       grp
);

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [31:0]            line_r, line_nxt;
  logic [47:0]            win_r, win_nxt;
  logic [7:0]             op_r, op_nxt;

  logic [5:0]             t_kind  [4];
  logic [OFFSET_BITS-1:0] t_start [4];
  logic [OFFSET_BITS-1:0] t_len   [4];
  logic [31:0]            t_line  [4];
  logic [2:0]             n;

  logic [OFFSET_BITS-1:0] pos, dotpos, spos;
  logic [7:0]             b;
  logic                   restart;
  logic [5:0]             sk;

  // tokens are appended in model order; line is sampled at append time
  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    win_nxt   = win_r;
    op_nxt    = op_r;
    n         = 3'd0;
    b         = char_byte;
    pos       = pos_r;
    dotpos    = pos_r - 1'b1;
    spos      = start_r + 1'b1;
    restart   = 1'b0;
    sk        = single_kind(b);
    for (int i = 0; i < 4; i++) begin
      t_kind[i]  = K_END;
      t_start[i] = '0;
      t_len[i]   = '0;
      t_line[i]  = line_r;
    end

    if (byte_present) begin
      unique case (mode_r)
        MODE_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            if (win_r[47:40] != 8'd0) win_nxt = WIN_FULL;
            else win_nxt = {win_r[39:0], b};
          end else begin
            t_kind[0] = kw_kind(win_r); t_start[0] = start_r; t_len[0] = pos - start_r;
            n = 3'd1; restart = 1'b1;
          end
        end
        MODE_INT: begin
          if (b == 8'h2E) mode_nxt = MODE_DOT;
          else if (!is_digit(b)) begin
            t_kind[0] = K_NUMBER; t_start[0] = start_r; t_len[0] = pos - start_r;
            n = 3'd1; restart = 1'b1;
          end
        end
        MODE_DOT: begin
          if (is_digit(b)) mode_nxt = MODE_FRAC;
          else begin
            t_kind[0] = K_NUMBER; t_start[0] = start_r; t_len[0] = dotpos - start_r;
            t_kind[1] = K_DOT; t_start[1] = dotpos; t_len[1] = OFFSET_BITS'(1);
            n = 3'd2; restart = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (!is_digit(b)) begin
            t_kind[0] = K_NUMBER; t_start[0] = start_r; t_len[0] = pos - start_r;
            n = 3'd1; restart = 1'b1;
          end
        end
        MODE_OP: begin
          if (b == 8'h3D) begin
            t_kind[0] = op_kind(op_r, 1'b1); t_start[0] = start_r;
            t_len[0] = OFFSET_BITS'(2); n = 3'd1; mode_nxt = MODE_IDLE;
          end else begin
            t_kind[0] = op_kind(op_r, 1'b0); t_start[0] = start_r;
            t_len[0] = OFFSET_BITS'(1); n = 3'd1; restart = 1'b1;
          end
        end
        MODE_STR: begin
          if (b == 8'h22) begin
            t_kind[0] = K_STRING; t_start[0] = spos; t_len[0] = pos - spos;
            n = 3'd1; mode_nxt = MODE_IDLE;
          end
        end
        default: restart = 1'b1;
      endcase

      if (restart) begin
        start_nxt = pos;
        mode_nxt  = MODE_IDLE;
        if (sk != K_NONE) begin
          t_kind[n[1:0]] = sk; t_start[n[1:0]] = pos; t_len[n[1:0]] = OFFSET_BITS'(1);
          n = n + 3'd1;
        end else if (b == 8'h21 || b == 8'h3C || b == 8'h3E || b == 8'h3D) begin
          mode_nxt = MODE_OP; op_nxt = b;
        end else if (b == 8'h22) begin
          mode_nxt = MODE_STR;
        end else if (b == 8'h20 || b == 8'h09 || b == 8'h0D) begin
          mode_nxt = MODE_IDLE;
        end else if (b == 8'h0A) begin
          line_nxt = line_r + 32'd1;
        end else if (is_alpha(b)) begin
          mode_nxt = MODE_IDENT; win_nxt = {40'd0, b};
        end else if (is_digit(b)) begin
          mode_nxt = MODE_INT;
        end else begin
          t_kind[n[1:0]] = K_BAD; t_start[n[1:0]] = pos; t_len[n[1:0]] = OFFSET_BITS'(1);
          n = n + 3'd1;
        end
      end
      pos_nxt = pos + 1'b1;
    end

    if (end_of_input) begin
      pos    = pos_nxt;
      dotpos = pos_nxt - 1'b1;
      // flush and end tokens see the line after this word's newline
      for (int i = 0; i < 4; i++) if (3'(i) >= n) t_line[i] = line_nxt;
      unique case (mode_nxt)
        MODE_IDENT: begin
          t_kind[n[1:0]] = kw_kind(win_nxt); t_start[n[1:0]] = start_nxt;
          t_len[n[1:0]] = pos - start_nxt; n = n + 3'd1;
        end
        MODE_INT, MODE_FRAC: begin
          t_kind[n[1:0]] = K_NUMBER; t_start[n[1:0]] = start_nxt;
          t_len[n[1:0]] = pos - start_nxt; n = n + 3'd1;
        end
        MODE_DOT: begin
          t_kind[n[1:0]] = K_NUMBER; t_start[n[1:0]] = start_nxt;
          t_len[n[1:0]] = dotpos - start_nxt; n = n + 3'd1;
          t_kind[n[1:0]] = K_DOT; t_start[n[1:0]] = dotpos;
          t_len[n[1:0]] = OFFSET_BITS'(1); n = n + 3'd1;
        end
        MODE_OP: begin
          t_kind[n[1:0]] = op_kind(op_nxt, 1'b0); t_start[n[1:0]] = start_nxt;
          t_len[n[1:0]] = OFFSET_BITS'(1); n = n + 3'd1;
        end
        MODE_STR: begin
          t_kind[n[1:0]] = K_UNKNOWN; t_start[n[1:0]] = start_nxt;
          t_len[n[1:0]] = pos - start_nxt; n = n + 3'd1;
        end
        default: ;
      endcase
      t_kind[n[1:0]] = K_END; t_start[n[1:0]] = pos; t_len[n[1:0]] = '0;
      n = n + 3'd1;
    end
  end

  // a token flushed by a newline keeps the line it ended on
  always_comb begin
    grp.cnt = n;
    for (int i = 0; i < 4; i++) begin
      grp.tok[i].kind  = t_kind[i];
      grp.tok[i].start = 32'(64'(t_start[i]));
      grp.tok[i].len   = 32'(64'(t_len[i]));
      grp.tok[i].line  = t_line[i];
      grp.tok[i].last  = (3'(i) + 3'd1 == n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      pos_r   <= '0;
      line_r  <= '0;
      win_r   <= '0;
      op_r    <= '0;
    end else if (take) begin
      if (end_of_input) begin
        mode_r  <= MODE_IDLE;
        start_r <= '0;
        pos_r   <= '0;
        line_r  <= '0;
        win_r   <= '0;
        op_r    <= '0;
      end else begin
        mode_r  <= mode_nxt;
        start_r <= start_nxt;
        pos_r   <= pos_nxt;
        line_r  <= line_nxt;
        win_r   <= win_nxt;
        op_r    <= op_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/kwlex_fifo.sv =====
module kwlex_fifo import kwlex_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  grp_t wr_data,
  output logic full,
  input  logic rd_en,
  output grp_t rd_data,
  output logic empty
);

  grp_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== rtl/core/kwlex_back.sv =====
module kwlex_back import kwlex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  grp_t        grp,
  input  logic        grp_valid,
  output logic        grp_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output tok_t        tok
);

  logic [1:0] idx_r;
  logic       fire;

  assign out_valid = grp_valid;
  assign tok       = grp.tok[idx_r];
  assign fire      = out_valid && out_ready;
  assign grp_pop   = fire && tok.last;

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else if (fire) idx_r <= tok.last ? 2'd0 : idx_r + 2'd1;
  end

endmodule

// ===== rtl/core/keyword_lexer_byte_stream_unit.sv =====
// Byte-stream lexer: takes one source byte per word and returns tokens (kind, start,
// length, line), up to four per input word, one token per cycle on the output while
// out_ready is high. The front classifies a byte combinationally and pushes its token
// group into a two-entry queue, which the back drains at that rate. A byte that yields
// no token takes no queue entry; a word causing several tokens holds the output until
// each is taken. Words with neither a byte nor end produce nothing.
module keyword_lexer_byte_stream_unit import kwlex_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [31:0] out_start_offset,
  output logic [31:0] out_token_length,
  output logic [31:0] out_line_number,
  output logic        out_last_of_run
);

  grp_t grp_in, grp_out;
  logic full, empty, take, pop;
  tok_t tok;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  kwlex_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst_n,
    .char_byte(in_char_byte), .byte_present(in_byte_present),
    .end_of_input(in_end_of_input), .take, .grp(grp_in)
  );

  kwlex_fifo u_fifo (
    .clk, .rst_n,
    .wr_en(take && grp_in.cnt != 3'd0), .wr_data(grp_in), .full,
    .rd_en(pop), .rd_data(grp_out), .empty
  );

  kwlex_back u_back (
    .clk, .rst_n,
    .grp(grp_out), .grp_valid(!empty), .grp_pop(pop),
    .out_valid, .out_ready, .tok
  );

  assign out_token_kind   = tok.kind;
  assign out_start_offset = tok.start;
  assign out_token_length = tok.len;
  assign out_line_number  = tok.line;
  assign out_last_of_run  = tok.last;

endmodule
